// ===== sv/rpr_pkg.sv =====
// Shared widths, constants and the arctangent table for the point rotation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rpr_pkg;

  localparam int ANGLE_W = 16;
  localparam int VS_W    = 30;
  localparam int PR_W    = 2 * VS_W;
  localparam int CW      = 61;
  localparam int CS_W    = 31;
  localparam int SQ_W    = 62;
  localparam int NW      = 64;
  localparam int NSQ     = 32;
  localparam int QW      = 31;
  localparam int NUMW    = CS_W + 30;
  localparam int KW      = 32;
  localparam int KP_W    = KW + VS_W;
  localparam int WW      = 33;
  localparam int CRW     = 36;
  localparam int RW      = 34;

  localparam logic signed [CRW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CRW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CRW-1:0] GAIN_Q30    = 36'sd652032874;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

endpackage
`default_nettype wire

// ===== sv/rpr_sqrt_cell.sv =====
// One step of the bit-serial integer square root.
`timescale 1ns / 1ps
`default_nettype none
module rpr_sqrt_cell import rpr_pkg::*; #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [SIDE_W-1:0] side_i,
  input  wire logic [NW-1:0]     n_i,
  input  wire logic [NW-1:0]     res_i,
  output logic                   vld_o,
  output logic [SIDE_W-1:0]      side_o,
  output logic [NW-1:0]          n_o,
  output logic [NW-1:0]          res_o
);

  localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * STEP);

  logic              vld_r;
  logic [SIDE_W-1:0] side_r;
  logic [NW-1:0]     n_r, res_r, n_nxt, res_nxt, trial;

  always_comb begin
    trial = res_i + BIT;
    if (n_i >= trial) begin
      n_nxt   = n_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      n_nxt   = n_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      n_r    <= n_nxt;
      res_r  <= res_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign n_o    = n_r;
  assign res_o  = res_r;

endmodule
`default_nettype wire

// ===== sv/rpr_div_cell.sv =====
// One quotient bit of the restoring divider, three lanes side by side.
`timescale 1ns / 1ps
`default_nettype none
module rpr_div_cell import rpr_pkg::*; #(
  parameter int QBIT   = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_i,
  input  wire logic [SIDE_W-1:0]     side_i,
  input  wire logic [QW-1:0]         len_i,
  input  wire logic [2:0][NUMW-1:0]  rem_i,
  input  wire logic [2:0][QW-1:0]    quo_i,
  output logic                       vld_o,
  output logic [SIDE_W-1:0]          side_o,
  output logic [QW-1:0]              len_o,
  output logic [2:0][NUMW-1:0]       rem_o,
  output logic [2:0][QW-1:0]         quo_o
);

  logic                 vld_r;
  logic [SIDE_W-1:0]    side_r;
  logic [QW-1:0]        len_r;
  logic [2:0][NUMW-1:0] rem_r, rem_nxt;
  logic [2:0][QW-1:0]   quo_r, quo_nxt;
  logic [NUMW-1:0]      dvs;

  always_comb begin
    dvs = NUMW'(len_i) << QBIT;
    for (int i = 0; i < 3; i++) begin
      rem_nxt[i] = rem_i[i];
      quo_nxt[i] = quo_i[i];
      if (rem_i[i] >= dvs) begin
        rem_nxt[i]       = rem_i[i] - dvs;
        quo_nxt[i][QBIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      len_r  <= len_i;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign len_o  = len_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;

endmodule
`default_nettype wire

// ===== sv/rpr_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation.
`timescale 1ns / 1ps
`default_nettype none
module rpr_cordic_cell import rpr_pkg::*; #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_i,
  input  wire logic [SIDE_W-1:0]     side_i,
  input  wire logic signed [CRW-1:0] x_i,
  input  wire logic signed [CRW-1:0] y_i,
  input  wire logic signed [CRW-1:0] z_i,
  output logic                       vld_o,
  output logic [SIDE_W-1:0]          side_o,
  output logic signed [CRW-1:0]      x_o,
  output logic signed [CRW-1:0]      y_o,
  output logic signed [CRW-1:0]      z_o
);

  localparam logic signed [CRW-1:0] ANG = $signed({{(CRW-32){1'b0}}, ATAN_Q30[STEP]});

  logic                  vld_r;
  logic [SIDE_W-1:0]     side_r;
  logic signed [CRW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;

  always_comb begin
    if (!z_i[CRW-1]) begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule
`default_nettype wire

// ===== sv/rodrigues_point_rotation.sv =====
// Throughput: one transaction per cycle; the 32 square-root cells, 31 divider cells
// and TRIG_ITERATIONS CORDIC cells each hold one item and advance every cycle.
// The pipeline stalls only when the output register is full and not taken.
// Reset: synchronous, active low; clears all valid flags, payload is left as is.
`timescale 1ns / 1ps
`default_nettype none
module rodrigues_point_rotation import rpr_pkg::*; #(
  parameter int COORD_WIDTH     = 32,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // pivot_x, pivot_y, pivot_z, end_x, end_y, end_z, ref_x, ref_y, ref_z, angle
  input  wire logic [((9*COORD_WIDTH+ANGLE_W+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // out_x, out_y, out_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // degenerate
  output logic [0:0] out_tuser
);

  localparam int W     = COORD_WIDTH;
  localparam int VW    = W + 1;
  localparam int SW    = $clog2(W);
  localparam int OUT_W = ((3*W+7)/8)*8;
  localparam int PO    = 0;
  localparam int EO    = 3 * W;
  localparam int VO    = 6 * W;
  localparam int SO    = VO + 3 * VS_W;
  localparam int AO    = SO + SW;
  localparam int DO    = AO + ANGLE_W;
  localparam int COM_W = DO + 1;
  localparam int SQS_W = 3 * CS_W + COM_W;
  localparam int DVS_W = 3 + COM_W;
  localparam int CRS_W = 1 + 3 * WW + COM_W;
  localparam int NT    = TRIG_ITERATIONS;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic [6:0] bitlen(input logic [63:0] u);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (u[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  logic en, stall;

  // stage 1: capture, form offset
  logic                s1_vld_r;
  logic [2:0][W-1:0]   s1_p_r, s1_e_r, s1_b_r, in_p, in_e, in_b;
  logic [2:0][VW-1:0]  s1_v_r, s1_v_nxt;
  logic [ANGLE_W-1:0]  s1_ang_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_p[i]     = in_tdata[i*W +: W];
      in_e[i]     = in_tdata[(3+i)*W +: W];
      in_b[i]     = in_tdata[(6+i)*W +: W];
      s1_v_nxt[i] = $signed(in_e[i]) - $signed(in_p[i]);
    end
  end

  // stage 2: fit shift counts
  logic                s2_vld_r;
  logic [2:0][W-1:0]   s2_p_r, s2_e_r, s2_b_r;
  logic [2:0][VW-1:0]  s2_v_r;
  logic [ANGLE_W-1:0]  s2_ang_r;
  logic [SW-1:0]       s2_s_r, s2_sb_r, s2_s_nxt, s2_sb_nxt;
  logic [63:0]         u_v, u_b;
  logic [6:0]          bl_v, bl_b;

  always_comb begin
    u_v = '0;
    u_b = '0;
    for (int i = 0; i < 3; i++) begin
      u_v = u_v | 64'(s1_v_r[i] ^ {VW{s1_v_r[i][VW-1]}});
      u_b = u_b | 64'(s1_b_r[i] ^ {W{s1_b_r[i][W-1]}});
    end
    bl_v      = bitlen(u_v);
    bl_b      = bitlen(u_b);
    s2_s_nxt  = (bl_v > 7'd29) ? SW'(bl_v - 7'd29) : '0;
    s2_sb_nxt = (bl_b > 7'd29) ? SW'(bl_b - 7'd29) : '0;
  end

  // stage 3: scaled vectors
  logic                 s3_vld_r;
  logic [2:0][VS_W-1:0] s3_vs_r, s3_bs_r, s3_vs_nxt, s3_bs_nxt;
  logic [COM_W-1:0]     s3_com_r, s3_com_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_vs_nxt[i] = VS_W'($signed(s2_v_r[i]) >>> s2_s_r);
      s3_bs_nxt[i] = VS_W'($signed(s2_b_r[i]) >>> s2_sb_r);
    end
    s3_com_nxt = {1'b0, s2_ang_r, s2_s_r, s3_vs_nxt, s2_e_r, s2_p_r};
  end

  // stage 4: cross product terms
  logic                 s4_vld_r;
  logic [5:0][PR_W-1:0] s4_pr_r, s4_pr_nxt;
  logic [COM_W-1:0]     s4_com_r;

  always_comb begin
    s4_pr_nxt[0] = $signed(s3_vs_r[1]) * $signed(s3_bs_r[2]);
    s4_pr_nxt[1] = $signed(s3_vs_r[2]) * $signed(s3_bs_r[1]);
    s4_pr_nxt[2] = $signed(s3_vs_r[2]) * $signed(s3_bs_r[0]);
    s4_pr_nxt[3] = $signed(s3_vs_r[0]) * $signed(s3_bs_r[2]);
    s4_pr_nxt[4] = $signed(s3_vs_r[0]) * $signed(s3_bs_r[1]);
    s4_pr_nxt[5] = $signed(s3_vs_r[1]) * $signed(s3_bs_r[0]);
  end

  // stage 5: cross product
  logic               s5_vld_r;
  logic [2:0][CW-1:0] s5_c_r, s5_c_nxt;
  logic [COM_W-1:0]   s5_com_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_c_nxt[i] = $signed(s4_pr_r[2*i]) - $signed(s4_pr_r[2*i+1]);
    end
  end

  // stage 6: magnitude bit length
  logic               s6_vld_r;
  logic [2:0][CW-1:0] s6_c_r;
  logic [6:0]         s6_bl_r, s6_bl_nxt;
  logic [COM_W-1:0]   s6_com_r;
  logic [63:0]        u_c;

  always_comb begin
    u_c = '0;
    for (int i = 0; i < 3; i++) begin
      u_c = u_c | 64'(s5_c_r[i][CW-1] ? CW'(-s5_c_r[i]) : s5_c_r[i]);
    end
    s6_bl_nxt = bitlen(u_c);
  end

  // stage 7: normalise
  logic                 s7_vld_r;
  logic [2:0][CS_W-1:0] s7_cs_r, s7_cs_nxt;
  logic [COM_W-1:0]     s7_com_r, s7_com_nxt;
  logic [6:0]           t_l, t_r;
  logic                 sh_left;

  always_comb begin
    sh_left = s6_bl_r < 7'd29;
    t_l     = 7'd29 - s6_bl_r;
    t_r     = (s6_bl_r > 7'd30) ? s6_bl_r - 7'd30 : 7'd0;
    for (int i = 0; i < 3; i++) begin
      s7_cs_nxt[i] = sh_left ? CS_W'($signed(s6_c_r[i]) <<< t_l)
                             : CS_W'($signed(s6_c_r[i]) >>> t_r);
    end
    s7_com_nxt = {(s6_bl_r == 7'd0), s6_com_r[COM_W-2:0]};
  end

  // stage 8: squares
  logic                 s8_vld_r;
  logic [2:0][SQ_W-1:0] s8_sq_r, s8_sq_nxt;
  logic [2:0][CS_W-1:0] s8_cs_r;
  logic [COM_W-1:0]     s8_com_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s8_sq_nxt[i] = $signed(s7_cs_r[i]) * $signed(s7_cs_r[i]);
    end
  end

  // stage 9: sum of squares
  logic                 s9_vld_r;
  logic [NW-1:0]        s9_n2_r, s9_n2_nxt;
  logic [2:0][CS_W-1:0] s9_cs_r;
  logic [COM_W-1:0]     s9_com_r;

  assign s9_n2_nxt = NW'(s8_sq_r[0]) + NW'(s8_sq_r[1]) + NW'(s8_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
      s9_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
      s9_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r   <= in_p;
      s1_e_r   <= in_e;
      s1_b_r   <= in_b;
      s1_v_r   <= s1_v_nxt;
      s1_ang_r <= in_tdata[9*W +: ANGLE_W];
      s2_p_r   <= s1_p_r;
      s2_e_r   <= s1_e_r;
      s2_b_r   <= s1_b_r;
      s2_v_r   <= s1_v_r;
      s2_ang_r <= s1_ang_r;
      s2_s_r   <= s2_s_nxt;
      s2_sb_r  <= s2_sb_nxt;
      s3_vs_r  <= s3_vs_nxt;
      s3_bs_r  <= s3_bs_nxt;
      s3_com_r <= s3_com_nxt;
      s4_pr_r  <= s4_pr_nxt;
      s4_com_r <= s3_com_r;
      s5_c_r   <= s5_c_nxt;
      s5_com_r <= s4_com_r;
      s6_c_r   <= s5_c_r;
      s6_bl_r  <= s6_bl_nxt;
      s6_com_r <= s5_com_r;
      s7_cs_r  <= s7_cs_nxt;
      s7_com_r <= s7_com_nxt;
      s8_sq_r  <= s8_sq_nxt;
      s8_cs_r  <= s7_cs_r;
      s8_com_r <= s7_com_r;
      s9_n2_r  <= s9_n2_nxt;
      s9_cs_r  <= s8_cs_r;
      s9_com_r <= s8_com_r;
    end
  end

  // square root chain
  logic             sq_vld  [NSQ+1];
  logic [SQS_W-1:0] sq_side [NSQ+1];
  logic [NW-1:0]    sq_n    [NSQ+1];
  logic [NW-1:0]    sq_res  [NSQ+1];

  assign sq_vld[0]  = s9_vld_r;
  assign sq_side[0] = {s9_cs_r, s9_com_r};
  assign sq_n[0]    = s9_n2_r;
  assign sq_res[0]  = '0;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    rpr_sqrt_cell #(.STEP(g), .SIDE_W(SQS_W)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(sq_vld[g]), .side_i(sq_side[g]), .n_i(sq_n[g]), .res_i(sq_res[g]),
      .vld_o(sq_vld[g+1]), .side_o(sq_side[g+1]), .n_o(sq_n[g+1]),
      .res_o(sq_res[g+1])
    );
  end

  // divider chain
  logic                 dv_vld  [QW+1];
  logic [DVS_W-1:0]     dv_side [QW+1];
  logic [QW-1:0]        dv_len  [QW+1];
  logic [2:0][NUMW-1:0] dv_rem  [QW+1];
  logic [2:0][QW-1:0]   dv_quo  [QW+1];
  logic [2:0][NUMW-1:0] dv_rem0;
  logic [2:0][CS_W-1:0] sq_cs;
  logic [2:0]           dv_sgn;

  always_comb begin
    sq_cs = sq_side[NSQ][COM_W +: 3*CS_W];
    for (int i = 0; i < 3; i++) begin
      dv_sgn[i]  = sq_cs[i][CS_W-1];
      dv_rem0[i] = {(dv_sgn[i] ? CS_W'(-sq_cs[i]) : sq_cs[i]), 30'b0};
    end
  end

  assign dv_vld[0]  = sq_vld[NSQ];
  assign dv_side[0] = {dv_sgn, sq_side[NSQ][COM_W-1:0]};
  assign dv_len[0]  = sq_res[NSQ][QW-1:0];
  assign dv_rem[0]  = dv_rem0;
  assign dv_quo[0]  = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    rpr_div_cell #(.QBIT(QW-1-g), .SIDE_W(DVS_W)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(dv_vld[g]), .side_i(dv_side[g]), .len_i(dv_len[g]),
      .rem_i(dv_rem[g]), .quo_i(dv_quo[g]),
      .vld_o(dv_vld[g+1]), .side_o(dv_side[g+1]), .len_o(dv_len[g+1]),
      .rem_o(dv_rem[g+1]), .quo_o(dv_quo[g+1])
    );
  end

  // stage K: signed unit axis
  logic               sk_vld_r;
  logic [2:0][KW-1:0] sk_k_r, sk_k_nxt;
  logic [COM_W-1:0]   sk_com_r;
  logic [2:0]         q_sgn;

  always_comb begin
    q_sgn = dv_side[QW][COM_W +: 3];
    for (int i = 0; i < 3; i++) begin
      sk_k_nxt[i] = q_sgn[i] ? -{1'b0, dv_quo[QW][i]} : {1'b0, dv_quo[QW][i]};
    end
  end

  // stage WP: axis cross offset terms
  logic                 wp_vld_r;
  logic [5:0][KP_W-1:0] wp_pr_r, wp_pr_nxt;
  logic [COM_W-1:0]     wp_com_r;
  logic [2:0][VS_W-1:0] k_vs;

  always_comb begin
    k_vs = sk_com_r[VO +: 3*VS_W];
    wp_pr_nxt[0] = $signed(sk_k_r[1]) * $signed(k_vs[2]);
    wp_pr_nxt[1] = $signed(sk_k_r[2]) * $signed(k_vs[1]);
    wp_pr_nxt[2] = $signed(sk_k_r[2]) * $signed(k_vs[0]);
    wp_pr_nxt[3] = $signed(sk_k_r[0]) * $signed(k_vs[2]);
    wp_pr_nxt[4] = $signed(sk_k_r[0]) * $signed(k_vs[1]);
    wp_pr_nxt[5] = $signed(sk_k_r[1]) * $signed(k_vs[0]);
  end

  // stage WD: round cross product, reduce angle
  logic                  wd_vld_r;
  logic [2:0][WW-1:0]    wd_w_r, wd_w_nxt;
  logic                  wd_neg_r, wd_neg_nxt;
  logic signed [CRW-1:0] wd_z_r, wd_z_nxt, z_raw;
  logic [COM_W-1:0]      wd_com_r;
  logic signed [KP_W:0]  wdiff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wdiff       = $signed(wp_pr_r[2*i]) - $signed(wp_pr_r[2*i+1]);
      wd_w_nxt[i] = WW'((wdiff + (KP_W+1)'(1 << 29)) >>> 30);
    end
    z_raw      = $signed(CRW'($signed(wp_com_r[AO +: ANGLE_W]))) <<< 17;
    wd_z_nxt   = z_raw;
    wd_neg_nxt = 1'b0;
    if (z_raw > HALF_PI_Q30) begin
      wd_z_nxt   = z_raw - PI_Q30;
      wd_neg_nxt = 1'b1;
    end else if (z_raw < -HALF_PI_Q30) begin
      wd_z_nxt   = z_raw + PI_Q30;
      wd_neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_vld_r <= 1'b0;
      wp_vld_r <= 1'b0;
      wd_vld_r <= 1'b0;
    end else if (en) begin
      sk_vld_r <= dv_vld[QW];
      wp_vld_r <= sk_vld_r;
      wd_vld_r <= wp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sk_k_r   <= sk_k_nxt;
      sk_com_r <= dv_side[QW][COM_W-1:0];
      wp_pr_r  <= wp_pr_nxt;
      wp_com_r <= sk_com_r;
      wd_w_r   <= wd_w_nxt;
      wd_neg_r <= wd_neg_nxt;
      wd_z_r   <= wd_z_nxt;
      wd_com_r <= wp_com_r;
    end
  end

  // CORDIC chain
  logic                  cr_vld  [NT+1];
  logic [CRS_W-1:0]      cr_side [NT+1];
  logic signed [CRW-1:0] cr_x    [NT+1];
  logic signed [CRW-1:0] cr_y    [NT+1];
  logic signed [CRW-1:0] cr_z    [NT+1];

  assign cr_vld[0]  = wd_vld_r;
  assign cr_side[0] = {wd_neg_r, wd_w_r, wd_com_r};
  assign cr_x[0]    = GAIN_Q30;
  assign cr_y[0]    = '0;
  assign cr_z[0]    = wd_z_r;

  for (genvar g = 0; g < NT; g++) begin : g_cordic
    rpr_cordic_cell #(.STEP(g), .SIDE_W(CRS_W)) u_cell (
      .clk, .rst_n, .en,
      .vld_i(cr_vld[g]), .side_i(cr_side[g]),
      .x_i(cr_x[g]), .y_i(cr_y[g]), .z_i(cr_z[g]),
      .vld_o(cr_vld[g+1]), .side_o(cr_side[g+1]),
      .x_o(cr_x[g+1]), .y_o(cr_y[g+1]), .z_o(cr_z[g+1])
    );
  end

  // stage F1: rotation terms
  logic                  f1_vld_r;
  logic [5:0][63:0]      f1_pr_r, f1_pr_nxt;
  logic [COM_W-1:0]      f1_com_r, cr_com;
  logic signed [CRW-1:0] cosv, sinv;
  logic [2:0][WW-1:0]    cr_w;
  logic [2:0][VS_W-1:0]  cr_vs;
  logic                  cr_neg;

  always_comb begin
    cr_com = cr_side[NT][COM_W-1:0];
    cr_w   = cr_side[NT][COM_W +: 3*WW];
    cr_neg = cr_side[NT][CRS_W-1];
    cr_vs  = cr_com[VO +: 3*VS_W];
    cosv   = cr_neg ? -cr_x[NT] : cr_x[NT];
    sinv   = cr_neg ? -cr_y[NT] : cr_y[NT];
    for (int i = 0; i < 3; i++) begin
      f1_pr_nxt[2*i]   = $signed(cr_vs[i]) * cosv;
      f1_pr_nxt[2*i+1] = $signed(cr_w[i]) * sinv;
    end
  end

  // stage F2: round offset
  logic               f2_vld_r;
  logic [2:0][RW-1:0] f2_r_r, f2_r_nxt;
  logic [COM_W-1:0]   f2_com_r;
  logic signed [63:0] fsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum        = $signed(f1_pr_r[2*i]) + $signed(f1_pr_r[2*i+1]) + 64'sd536870912;
      f2_r_nxt[i] = RW'(fsum >>> 30);
    end
  end

  // output register
  logic              out_vld_r;
  logic [2:0][W-1:0] out_xyz_r, out_xyz_nxt, f2_p, f2_e;
  logic              out_deg_r;
  logic [SW-1:0]     f2_s;
  logic signed [63:0] fin;

  always_comb begin
    f2_p = f2_com_r[PO +: 3*W];
    f2_e = f2_com_r[EO +: 3*W];
    f2_s = f2_com_r[SO +: SW];
    for (int i = 0; i < 3; i++) begin
      fin = ($signed(64'($signed(f2_r_r[i]))) <<< f2_s) + 64'($signed(f2_p[i]));
      if (f2_com_r[DO]) begin
        out_xyz_nxt[i] = f2_e[i];
      end else if (fin > SAT_HI) begin
        out_xyz_nxt[i] = W'(SAT_HI);
      end else if (fin < SAT_LO) begin
        out_xyz_nxt[i] = W'(SAT_LO);
      end else begin
        out_xyz_nxt[i] = W'(fin);
      end
    end
  end

  assign stall = out_vld_r && !out_tready;
  assign en    = !(stall && f2_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r  <= 1'b0;
      f2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en) begin
        f1_vld_r <= cr_vld[NT];
        f2_vld_r <= f1_vld_r;
      end
      if (!stall) begin
        out_vld_r <= f2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_pr_r  <= f1_pr_nxt;
      f1_com_r <= cr_com;
      f2_r_r   <= f2_r_nxt;
      f2_com_r <= f1_com_r;
    end
    if (!stall) begin
      out_xyz_r <= out_xyz_nxt;
      out_deg_r <= f2_com_r[DO];
    end
  end

  assign in_tready  = en && rst_n;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'(out_xyz_r);
  assign out_tuser  = out_deg_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the Rodrigues point rotation pipeline.
`timescale 1ns / 1ps
module tb;
  import rpr_pkg::*;

  localparam int CWID    = 32;
  localparam int ITER    = 16;
  localparam int LATENCY = 78 + ITER;
  localparam int STALL_LIMIT = 4000;
  localparam longint HALF30  = 64'sd536870912;
  localparam longint ONE30   = 64'sd1073741824;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;

  typedef struct {
    logic signed [31:0] piv [3];
    logic signed [31:0] pt  [3];
    logic signed [31:0] rv  [3];
    logic signed [15:0] ang;
  } rot_item_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic               degen;
  } rot_res_t;

  class rotation_scoreboard;
    rot_res_t pending_q[$];
    int       errors;

    static function int fit_shift(longint a0, longint a1, longint a2);
      int s;
      for (s = 0; s < 63; s++) begin
        if ((a0 >>> s) < HALF30 && (a0 >>> s) >= -HALF30 &&
            (a1 >>> s) < HALF30 && (a1 >>> s) >= -HALF30 &&
            (a2 >>> s) < HALF30 && (a2 >>> s) >= -HALF30) break;
      end
      return s;
    endfunction

    static function logic [63:0] absval(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    static function longint round30(longint x);
      return (x + HALF30) >>> 30;
    endfunction

    static function rot_res_t rotate_point(rot_item_t it);
      rot_res_t    r;
      longint      p[3], v[3], vs[3], bs[3], c[3], k[3], w[3];
      longint      x, y, z, nx, a, acc;
      int          s, sb, t, i;
      logic [63:0] m, n2, len, rsq, bt;
      bit          neg;
      for (i = 0; i < 3; i++) begin
        p[i] = it.piv[i];
        v[i] = longint'(it.pt[i]) - p[i];
      end
      s  = fit_shift(v[0], v[1], v[2]);
      sb = fit_shift(it.rv[0], it.rv[1], it.rv[2]);
      for (i = 0; i < 3; i++) begin
        vs[i] = v[i] >>> s;
        bs[i] = longint'(it.rv[i]) >>> sb;
      end
      c[0] = vs[1] * bs[2] - vs[2] * bs[1];
      c[1] = vs[2] * bs[0] - vs[0] * bs[2];
      c[2] = vs[0] * bs[1] - vs[1] * bs[0];
      m = absval(c[0]);
      if (absval(c[1]) > m) m = absval(c[1]);
      if (absval(c[2]) > m) m = absval(c[2]);
      if (m == 0) begin
        for (i = 0; i < 3; i++) r.pos[i] = it.pt[i];
        r.degen = 1'b1;
        return r;
      end
      t = 0;
      if (m < (64'd1 << 28)) begin
        while ((m << t) < (64'd1 << 28)) t++;
        for (i = 0; i < 3; i++) c[i] = c[i] <<< t;
      end else begin
        while ((m >> t) >= (64'd1 << 30)) t++;
        for (i = 0; i < 3; i++) c[i] = c[i] >>> t;
      end
      n2 = 0;
      for (i = 0; i < 3; i++) n2 += 64'(c[i] * c[i]);
      rsq = 0;
      bt  = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
        if (n2 >= rsq + bt) begin
          n2  = n2 - (rsq + bt);
          rsq = (rsq >> 1) + bt;
        end else begin
          rsq = rsq >> 1;
        end
        bt = bt >> 2;
      end
      len = (rsq == 0) ? 64'd1 : rsq;
      for (i = 0; i < 3; i++) k[i] = (c[i] * ONE30) / longint'(len);
      w[0] = round30(k[1] * vs[2] - k[2] * vs[1]);
      w[1] = round30(k[2] * vs[0] - k[0] * vs[2]);
      w[2] = round30(k[0] * vs[1] - k[1] * vs[0]);

      x = longint'(GAIN_Q30);
      y = 0;
      z = longint'(it.ang) * 131072;
      neg = 1'b0;
      if (z > longint'(HALF_PI_Q30)) begin
        z = z - longint'(PI_Q30);
        neg = 1'b1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
        z = z + longint'(PI_Q30);
        neg = 1'b1;
      end
      for (i = 0; i < ITER; i++) begin
        a = (i < 32) ? longint'(ATAN_Q30[i]) : 0;
        if (z >= 0) begin
          nx = x - (y >>> (i > 63 ? 63 : i));
          y  = y + (x >>> (i > 63 ? 63 : i));
          z  = z - a;
        end else begin
          nx = x + (y >>> (i > 63 ? 63 : i));
          y  = y - (x >>> (i > 63 ? 63 : i));
          z  = z + a;
        end
        x = nx;
      end
      if (neg) begin
        x = -x;
        y = -y;
      end
      for (i = 0; i < 3; i++) begin
        acc = round30(vs[i] * x + w[i] * y);
        acc = acc * (64'sd1 <<< s) + p[i];
        if (acc > longint'(CMAX)) acc = CMAX;
        if (acc < longint'(CMIN)) acc = CMIN;
        r.pos[i] = acc[31:0];
      end
      r.degen = 1'b0;
      return r;
    endfunction

    function void note_input(rot_item_t it);
      pending_q.push_back(rotate_point(it));
    endfunction

    function void check_result(logic [95:0] data, logic flag);
      rot_res_t e;
      int i;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction %h", data);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      for (i = 0; i < 3; i++) begin
        if (data[32*i +: 32] !== e.pos[i]) begin
          $error("out_%s exp %0d got %0d", i == 0 ? "x" : (i == 1 ? "y" : "z"),
                 e.pos[i], $signed(data[32*i +: 32]));
          errors++;
        end
      end
      if (flag !== e.degen) begin
        $error("degenerate exp %0d got %0d", e.degen, flag);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [303:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [0:0]   out_tuser;

  rotation_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int quiet_cycles;

  rodrigues_point_rotation #(
    .COORD_WIDTH(CWID),
    .TRIG_ITERATIONS(ITER)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rot_item_t make_item(int px, int py, int pz, int ex, int ey, int ez,
                                          int bx, int by, int bz, int an);
    rot_item_t it;
    it.piv = '{px, py, pz};
    it.pt  = '{ex, ey, ez};
    it.rv  = '{bx, by, bz};
    it.ang = an[15:0];
    return it;
  endfunction

  function automatic int small_val(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int wide_val();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic rot_item_t random_item();
    rot_item_t it;
    int i, mode, f;
    mode = $urandom_range(0, 9);
    f = $urandom_range(1, 4);
    for (i = 0; i < 3; i++) begin
      case (mode)
        0, 1, 2: begin
          it.piv[i] = $urandom;
          it.pt[i]  = $urandom;
          it.rv[i]  = $urandom;
        end
        3, 4: begin
          it.piv[i] = wide_val();
          it.pt[i]  = it.piv[i] + small_val(1 << 20);
          it.rv[i]  = small_val(1 << 18);
        end
        5: begin
          it.piv[i] = wide_val();
          it.rv[i]  = small_val(1 << 12);
          it.pt[i]  = it.piv[i] + it.rv[i] * f;
        end
        6: begin
          it.piv[i] = wide_val();
          it.pt[i]  = ($urandom_range(0, 3) == 0) ? it.piv[i] : wide_val();
          it.rv[i]  = ($urandom_range(0, 1) == 0) ? 0 : small_val(8);
        end
        default: begin
          it.piv[i] = wide_val();
          it.pt[i]  = wide_val();
          it.rv[i]  = wide_val();
        end
      endcase
    end
    it.ang = 16'($urandom);
    return it;
  endfunction

  task automatic send_item(rot_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tdata  = {it.ang, it.rv[2], it.rv[1], it.rv[0], it.pt[2], it.pt[1], it.pt[0],
                 it.piv[2], it.piv[1], it.piv[0]};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rot_item_t directed[$];
    int ph, n;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(65536, 2, 3, 65536, 2, 3, 1, 2, 3, 100));
    directed.push_back(make_item(0, 0, 0, 65536, 0, 0, 0, 0, 0, 100));
    directed.push_back(make_item(0, 0, 0, 131072, 262144, 393216, 1, 2, 3, 4000));
    directed.push_back(make_item(0, 0, 0, 65536, 0, 0, 0, 0, 65536, 12868));
    directed.push_back(make_item(0, 0, 0, 65536, 0, 0, 0, 0, 65536, -32768));
    directed.push_back(make_item(0, 0, 0, 65536, 0, 0, 0, 0, 65536, 32767));
    directed.push_back(make_item(100, 0, 0, 0, 65536, 0, 65536, 0, 0, 12869));
    directed.push_back(make_item(100, 0, 0, 0, 65536, 0, 65536, 0, 0, -12869));
    directed.push_back(make_item(CMIN, CMIN, CMIN, CMAX, CMAX, 0, 0, 65536, 0, 32767));
    directed.push_back(make_item(CMAX, CMAX, 0, CMIN, CMIN, CMIN, 65536, 0, 0, -32768));
    directed.push_back(make_item(0, 0, 0, 1, 0, 0, 0, 1, 0, 6434));
    directed.push_back(make_item(0, 0, 0, 3, -5, 7, CMAX, CMIN, CMAX, -6434));
    directed.push_back(make_item(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                                 32767));
    directed.push_back(make_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                 -32768));
    directed.push_back(make_item(0, 0, 0, 1, 0, 0, CMIN, 1, 0, 5000));
    directed.push_back(make_item(-7000, 9000, 12345, 70000, -3000, 500, 1000, 2000, -3000,
                                 0));
    directed.push_back(make_item(CMIN, 0, CMAX, CMAX, -1, CMIN, -1, -1, -1, -1));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    for (ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 61 : 0;
      rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 37 : 0;
      for (n = 0; n < 344; n++) begin
        if (ph == 2 && n == 0) rx_hold = 400;
        if (ph == 2 && n == 200) drain();
        send_item(random_item());
      end
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
